// ----- hw/rtl/csev_pkg.sv -----
package csev_pkg;

    // Default sizes
    localparam int MAX_BASES_DEF       = 16;
    localparam int COS_TABLE_DEPTH_DEF = 256;

    // Fixed field widths
    localparam int CNT_W    = 5;    // num_bases register width
    localparam int WIDX_W   = 4;    // weight_index width
    localparam int WEIGHT_W = 32;   // Q16.16 weight
    localparam int POINT_W  = 20;   // Q4.16 point
    localparam int PHASE_W  = 17;   // half-turn phase
    localparam int COS_W    = 16;   // signed Q1.15 cosine
    localparam int MAG_W    = 15;   // table magnitude
    localparam int PROD_W   = WEIGHT_W + COS_W;
    localparam int ACC_W    = 52;   // holds up to 31 full-scale products
    localparam int RES_W    = 32;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Taylor series constants for the quarter-wave table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_DIV [0:9] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } csev_state_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } csev_mac_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic [RES_W-1:0]  value;
        logic              sat;
    } csev_mac_stat_t;

    // One quarter-wave entry from a Q30 angle: cos by ten Taylor terms,
    // rounded half up to Q15 and clamped to [0, 32767].
    function automatic logic [MAG_W-1:0] quarter_cos(input logic [63:0] theta);
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rnd;
        logic [3:0]         n;
        t2   = (theta * theta) >> 30;
        term = ONE_Q30;
        acc  = ONE_Q30;
        for (n = 4'd0; n < 4'd10; n++)
        begin
            term = ((term * t2) >> 30) / TAYLOR_DIV[n];
            if (n[0] == 1'b0)
                acc = acc - term;
            else
                acc = acc + term;
        end
        if (acc[63])
            acc = '0;
        rnd = ((64'(acc) << 15) + (64'd1 << 29)) >> 30;
        if (rnd > 64'd32767)
            return {MAG_W{1'b1}};
        return rnd[MAG_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/csev_ram.sv -----
module csev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/csev_cos_rom.sv -----
module csev_cos_rom #(
    parameter int COS_TABLE_DEPTH = csev_pkg::COS_TABLE_DEPTH_DEF,
    localparam int KW = $clog2(COS_TABLE_DEPTH + 1)
) (
    input  logic                                clk,
    input  logic [csev_pkg::PHASE_W-1:0]        phase,
    output logic signed [csev_pkg::COS_W-1:0]   cos_val
);

    logic [csev_pkg::MAG_W-1:0]     cos_rom [0:COS_TABLE_DEPTH];
    logic [1:0]                     quad;
    logic [14:0]                    off;
    logic [15+KW-1:0]               scaled;
    logic [KW-1:0]                  k_idx;
    logic [KW-1:0]                  m_idx;
    logic [KW-1:0]                  sel_idx;
    logic [csev_pkg::MAG_W-1:0]     mag;
    logic signed [csev_pkg::COS_W-1:0] cos_next;
    logic signed [csev_pkg::COS_W-1:0] cos_reg;

    // Build the quarter-wave table at elaboration
    for (genvar k = 0; k <= COS_TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [63:0] THETA =
            (csev_pkg::HALF_PI_Q30 * 64'(k)) / COS_TABLE_DEPTH;
        localparam logic [csev_pkg::MAG_W-1:0] ENTRY = csev_pkg::quarter_cos(THETA);
        assign cos_rom[k] = ENTRY;
    end

    // Map phase to quadrant and table index
    always_comb
    begin
        quad    = phase[16:15];
        off     = phase[14:0];
        scaled  = (15 + KW)'(off) * (15 + KW)'(COS_TABLE_DEPTH);
        k_idx   = scaled[15 +: KW];
        m_idx   = KW'(COS_TABLE_DEPTH) - k_idx;
        sel_idx = quad[0] ? m_idx : k_idx;
        mag     = cos_rom[sel_idx];
        if (quad == 2'd1 || quad == 2'd2)
            cos_next = -$signed({1'b0, mag});
        else
            cos_next = $signed({1'b0, mag});
    end

    // Register the lookup to line up with the weight read
    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
    end

    assign cos_val = cos_reg;

endmodule

// ----- hw/rtl/csev_mac.sv -----
module csev_mac (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  csev_pkg::csev_mac_ctrl_t                ctrl,
    input  logic signed [csev_pkg::WEIGHT_W-1:0]    weight,
    input  logic signed [csev_pkg::COS_W-1:0]       cos_val,
    output csev_pkg::csev_mac_stat_t                stat
);

    localparam int Q_W = csev_pkg::ACC_W - 15;

    logic signed [csev_pkg::PROD_W-1:0] prod_reg;
    logic                               prod_valid_reg;
    logic signed [csev_pkg::ACC_W-1:0]  acc_reg;
    logic signed [csev_pkg::ACC_W-1:0]  acc_next;
    logic signed [csev_pkg::ACC_W-1:0]  rounded;
    logic signed [Q_W-1:0]              q;
    logic                               sat;
    logic [csev_pkg::RES_W-1:0]         value;

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else
            prod_valid_reg <= ctrl.mul_en;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= weight * cos_val;
    end

    // Accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (prod_valid_reg)
            acc_next = acc_reg + csev_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Round half up to Q16.16 and clip to 32 bits
    always_comb
    begin
        rounded = acc_reg + csev_pkg::ACC_W'(16384);
        q       = rounded[csev_pkg::ACC_W-1:15];
        sat     = (q[Q_W-1:csev_pkg::RES_W-1] != {(Q_W - csev_pkg::RES_W + 1){1'b0}}) &&
                  (q[Q_W-1:csev_pkg::RES_W-1] != {(Q_W - csev_pkg::RES_W + 1){1'b1}});
        if (!sat)
            value = q[csev_pkg::RES_W-1:0];
        else if (q[Q_W-1])
            value = {1'b1, {(csev_pkg::RES_W - 1){1'b0}}};
        else
            value = {1'b0, {(csev_pkg::RES_W - 1){1'b1}}};
    end

    assign stat.busy  = prod_valid_reg;
    assign stat.value = value;
    assign stat.sat   = sat;

endmodule

// ----- hw/rtl/cosine_series_evaluator.sv -----
// Evaluator of sum weight[i] * cos(pi * i * x) over i < min(num_bases, MAX_BASES).
// Weight write: one transfer per cycle while idle, stored at that edge, no result.
// Evaluate: one RAM read per basis, then multiply and accumulate; the next item
// is accepted only after the rounded sum loads into the output register, later
// while a held result waits. Reset: num_bases returns to 1 and all weight valid bits
// clear, so the table reads as zeros until written; no clearing pass is needed.
module cosine_series_evaluator #(
    parameter int MAX_BASES       = csev_pkg::MAX_BASES_DEF,
    parameter int COS_TABLE_DEPTH = csev_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [csev_pkg::CNT_W-1:0]              cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    opcode,
    input  logic [csev_pkg::WIDX_W-1:0]             weight_index,
    input  logic signed [csev_pkg::WEIGHT_W-1:0]    weight_value,
    input  logic signed [csev_pkg::POINT_W-1:0]     point,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [csev_pkg::RES_W-1:0]       series_value,
    output logic                                    saturated
);

    localparam int IDX_W = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;

    csev_pkg::csev_state_t              state_reg;
    csev_pkg::csev_state_t              state_next;
    logic [csev_pkg::CNT_W-1:0]         num_bases_reg;
    logic [csev_pkg::CNT_W-1:0]         n_reg;
    logic [csev_pkg::CNT_W-1:0]         n_clamped;
    logic [csev_pkg::CNT_W-1:0]         cnt_reg;
    logic [csev_pkg::PHASE_W-1:0]       x_reg;
    logic [csev_pkg::PHASE_W-1:0]       phase_reg;
    logic [MAX_BASES-1:0]               wvalid_reg;
    logic                               s1_valid_reg;
    logic                               s1_wv_reg;
    logic                               out_valid_reg;
    logic [csev_pkg::RES_W-1:0]         series_value_reg;
    logic                               saturated_reg;

    logic                               in_xfer;
    logic                               eval_start;
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_addr;
    logic [IDX_W-1:0]                   rd_addr;
    logic                               issue;
    logic                               drained;
    logic                               out_load;
    logic [csev_pkg::WEIGHT_W-1:0]      rd_data;
    logic signed [csev_pkg::WEIGHT_W-1:0] weight_eff;
    logic signed [csev_pkg::COS_W-1:0]  cos_val;
    csev_pkg::csev_mac_ctrl_t           mac_ctrl;
    csev_pkg::csev_mac_stat_t           mac_stat;

    // Input transfer decode
    assign in_xfer    = in_valid && in_ready;
    assign eval_start = in_xfer && (opcode == csev_pkg::OP_EVAL);
    assign wr_en      = in_xfer && (opcode == csev_pkg::OP_WRITE) &&
                        (32'(weight_index) < 32'(MAX_BASES));
    assign wr_addr    = IDX_W'(weight_index);
    assign rd_addr    = IDX_W'(cnt_reg);
    assign n_clamped  = (32'(num_bases_reg) > 32'(MAX_BASES)) ?
                        csev_pkg::CNT_W'(MAX_BASES) : num_bases_reg;
    assign drained    = (cnt_reg == n_reg) && !s1_valid_reg && !mac_stat.busy;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csev_pkg::ST_IDLE:
            begin
                if (eval_start)
                    state_next = csev_pkg::ST_RUN;
            end
            csev_pkg::ST_RUN:
            begin
                if (drained)
                    state_next = csev_pkg::ST_DONE;
            end
            csev_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = csev_pkg::ST_IDLE;
            end
            default:
                state_next = csev_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            csev_pkg::ST_IDLE:
                in_ready = 1'b1;
            csev_pkg::ST_RUN:
                issue = (cnt_reg != n_reg);
            csev_pkg::ST_DONE:
                out_load = !out_valid_reg || out_ready;
            default:
                in_ready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csev_pkg::ST_IDLE;
            num_bases_reg <= csev_pkg::CNT_W'(1);
            wvalid_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            if (cfg_we)
                num_bases_reg <= cfg_wdata;
            if (wr_en)
                wvalid_reg[wr_addr] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Basis counter and phase step
    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            n_reg     <= n_clamped;
            cnt_reg   <= '0;
            x_reg     <= point[csev_pkg::PHASE_W-1:0];
            phase_reg <= '0;
        end
        else if (issue)
        begin
            cnt_reg   <= cnt_reg + 1'b1;
            phase_reg <= phase_reg + x_reg;
        end
        if (issue)
            s1_wv_reg <= wvalid_reg[rd_addr];
        if (out_load)
        begin
            series_value_reg <= mac_stat.value;
            saturated_reg    <= mac_stat.sat;
        end
    end

    // Weight store
    csev_ram #(
        .WIDTH (csev_pkg::WEIGHT_W),
        .DEPTH (MAX_BASES)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (weight_value),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Cosine lookup
    csev_cos_rom #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .clk     (clk),
        .phase   (phase_reg),
        .cos_val (cos_val)
    );

    // Entries never written read as zero
    assign weight_eff = s1_wv_reg ? $signed(rd_data) : '0;

    assign mac_ctrl.clear  = eval_start;
    assign mac_ctrl.mul_en = s1_valid_reg;

    csev_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .weight  (weight_eff),
        .cos_val (cos_val),
        .stat    (mac_stat)
    );

    assign out_valid    = out_valid_reg;
    assign series_value = $signed(series_value_reg);
    assign saturated    = saturated_reg;

    // Pipeline is empty whenever a new item may transfer
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csev_pkg::ST_IDLE) |-> (!s1_valid_reg && !mac_stat.busy))
        else $error("pipeline busy while idle");

    // Weight reads only happen while a point is being evaluated
    a_read_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(state_reg == csev_pkg::ST_RUN))
        else $error("weight read outside evaluation");

    // A finished sum waits while the output slot is still occupied
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csev_pkg::ST_DONE && out_valid_reg && !out_ready)
            |=> (state_reg == csev_pkg::ST_DONE))
        else $error("result dropped while output stalled");

    // Basis counter never passes the count in use
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csev_pkg::ST_RUN) |-> (cnt_reg <= n_reg))
        else $error("basis counter overran");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int     NUM_WEIGHTS = 16;
    localparam int     QUARTER     = 256;
    localparam longint SUM_MAX     = 64'sd2147483647;
    localparam longint SUM_MIN     = -64'sd2147483648;

    typedef struct {
        logic        op;
        logic [3:0]  widx;
        logic [31:0] wval;
        logic [19:0] pt;
    } series_item_t;

    typedef struct {
        logic [31:0] sum;
        logic        clip;
    } series_result_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [4:0]          cfg_wdata    = '0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic                opcode       = csev_pkg::OP_WRITE;
    logic [3:0]          weight_index = '0;
    logic signed [31:0]  weight_value = '0;
    logic signed [19:0]  point        = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic signed [31:0]  series_value;
    logic                saturated;

    // Predictor state
    int             cos_tab [0:QUARTER];
    logic [31:0]    weight_mem [NUM_WEIGHTS];
    logic [4:0]     model_bases;

    series_item_t   pending_items [$];
    series_result_t expected_sums [$];
    series_item_t   drv_item;

    int  send_gap;
    int  recv_gap;
    bit  no_idle;
    int  n_errors;
    int  n_writes;
    int  n_evals;
    int  n_sat;
    int  n_checked;
    int  n_settings;

    cosine_series_evaluator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .weight_index (weight_index),
        .weight_value (weight_value),
        .point        (point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .series_value (series_value),
        .saturated    (saturated)
    );

    always #6 clk = ~clk;

    // Build the quarter-wave cosine magnitudes from a Q30 Taylor series
    function automatic void build_cos_table();
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned mag;
        longint          acc;
        int unsigned     k;
        int unsigned     n;
        for (k = 0; k <= QUARTER; k++)
        begin
            theta = (csev_pkg::HALF_PI_Q30 * 64'(k)) / 64'(QUARTER);
            t2    = (theta * theta) >> 30;
            term  = csev_pkg::ONE_Q30;
            acc   = csev_pkg::ONE_Q30;
            for (n = 1; n <= 10; n++)
            begin
                term = ((term * t2) >> 30) / (64'(2 * n - 1) * 64'(2 * n));
                if (n[0])
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            mag = acc;
            mag = (mag * 64'd32768 + (64'd1 << 29)) >> 30;
            if (mag > 64'd32767)
                mag = 64'd32767;
            cos_tab[k] = int'(mag);
        end
    endfunction

    // Weighted cosine sum at one point, rounded to Q16.16 and clipped
    function automatic series_result_t predict_series(input logic [19:0] pt);
        series_result_t res;
        int             n;
        int unsigned    i;
        logic [31:0]    xw;
        logic [31:0]    ph;
        int             k;
        int             c;
        longint         acc;
        longint         q;
        n   = (model_bases > NUM_WEIGHTS) ? NUM_WEIGHTS : int'(model_bases);
        xw  = {{12{pt[19]}}, pt};
        acc = 0;
        for (i = 0; i < n; i++)
        begin
            ph = i * xw;
            k  = int'(ph[14:7]);
            case (ph[16:15])
                2'b00:   c =  cos_tab[k];
                2'b01:   c = -cos_tab[QUARTER - k];
                2'b10:   c = -cos_tab[k];
                default: c =  cos_tab[QUARTER - k];
            endcase
            acc = acc + longint'($signed(weight_mem[i])) * longint'(c);
        end
        // round half up: floor of (acc + half) / 2^15
        q        = (acc + 64'sd16384) >>> 15;
        res.clip = 1'b0;
        if (q > SUM_MAX)
        begin
            q        = SUM_MAX;
            res.clip = 1'b1;
        end
        else if (q < SUM_MIN)
        begin
            q        = SUM_MIN;
            res.clip = 1'b1;
        end
        res.sum = q[31:0];
        return res;
    endfunction

    // Update the table or queue an expected sum for one transfer
    function automatic void apply_item(input logic op, input logic [3:0] idx,
                                       input logic [31:0] val, input logic [19:0] pt);
        series_result_t res;
        if (op == csev_pkg::OP_WRITE)
        begin
            weight_mem[idx] = val;
            n_writes++;
        end
        else
        begin
            res = predict_series(pt);
            expected_sums.push_back(res);
            n_evals++;
            if (res.clip)
                n_sat++;
        end
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void push_write(input logic [3:0] idx, input logic [31:0] val);
        series_item_t it;
        it.op   = csev_pkg::OP_WRITE;
        it.widx = idx;
        it.wval = val;
        it.pt   = 20'($urandom());
        pending_items.push_back(it);
    endfunction

    function automatic void push_eval(input logic [19:0] pt);
        series_item_t it;
        it.op   = csev_pkg::OP_EVAL;
        it.widx = 4'($urandom());
        it.wval = $urandom();
        it.pt   = pt;
        pending_items.push_back(it);
    endfunction

    function automatic logic [31:0] rand_weight();
        logic [31:0] v;
        int          r;
        v = $urandom();
        r = $urandom_range(0, 99);
        if (r < 30)
            return v;
        if (r < 70)
            return {{12{v[19]}}, v[19:0]};
        if (r < 85)
            return {{16{v[15]}}, v[15:0]};
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0001_0000;
            3:       return 32'hFFFF_0000;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [19:0] rand_point();
        logic [31:0] v;
        int          r;
        v = $urandom();
        r = $urandom_range(0, 99);
        if (r < 45)
            return v[19:0];
        if (r < 70)
            return {{2{v[17]}}, v[17:0]};
        if (r < 90)
            return {v[5:0], 14'b0};
        case ($urandom_range(0, 4))
            0:       return 20'h7FFFF;
            1:       return 20'h80000;
            2:       return 20'h10000;
            3:       return 20'hF0000;
            default: return 20'h00000;
        endcase
    endfunction

    // Wait until nothing is queued, in flight or outstanding
    task automatic settle();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_sums.size() != 0)
            @(negedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_bases(input logic [4:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        model_bases  = v;
        n_settings++;
        @(negedge clk);
    endtask

    // Driver: present queued items, hold each until it transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_item(opcode, weight_index, weight_value, point);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    drv_item      = pending_items.pop_front();
                    in_valid     <= 1'b1;
                    opcode       <= drv_item.op;
                    weight_index <= drv_item.widx;
                    weight_value <= drv_item.wval;
                    point        <= drv_item.pt;
                    send_gap     <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each transfer with the oldest expected sum
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected result series_value=%h saturated=%b",
                             $time, series_value, saturated);
                    n_errors++;
                end
                else
                begin
                    series_result_t res;
                    res = expected_sums.pop_front();
                    n_checked++;
                    if (series_value !== res.sum)
                    begin
                        $display("%0t: series_value expected %h actual %h",
                                 $time, res.sum, series_value);
                        n_errors++;
                    end
                    if (saturated !== res.clip)
                    begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, res.clip, saturated);
                        n_errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap  <= pick_gap();
            end
        end
    end

    // Stimulus
    initial
    begin
        int          p;
        int          j;
        logic [4:0]  bases_plan [10];

        build_cos_table();
        foreach (weight_mem[w])
            weight_mem[w] = '0;
        model_bases = 5'd1;
        no_idle     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table, then one base at full scale and at the point extremes
        push_eval(20'h00000);
        push_write(4'd0, 32'h7FFF_FFFF);
        push_eval(20'h00000);
        push_eval(20'h10000);
        push_write(4'd0, 32'h8000_0000);
        push_eval(20'h80000);
        push_eval(20'h7FFFF);

        // Two full-scale bases: clip high, then clip low
        settle();
        write_bases(5'd2);
        push_write(4'd1, 32'h7FFF_FFFF);
        push_write(4'd0, 32'h7FFF_FFFF);
        push_eval(20'h00000);
        push_write(4'd0, 32'h8000_0000);
        push_write(4'd1, 32'h8000_0000);
        push_eval(20'h00000);
        push_eval(20'h10000);

        // No bases: empty sum
        settle();
        write_bases(5'd0);
        push_eval(20'h7FFFF);
        push_eval(20'h12345);

        // Count beyond the table size is clipped to the table size
        settle();
        write_bases(5'd31);
        push_write(4'd15, 32'h0001_0000);
        push_write(4'd7, 32'hFFFF_0000);
        push_eval(20'h08000);
        push_eval(20'hFFFFF);

        settle();
        write_bases(5'd17);
        push_eval(20'h04000);
        push_eval(20'hC0000);

        // Random phases, each under its own base count
        bases_plan[0] = 5'd16;
        bases_plan[1] = 5'd1;
        bases_plan[2] = 5'd31;
        bases_plan[3] = 5'd0;
        bases_plan[4] = 5'd17;
        for (p = 5; p < 10; p++)
            bases_plan[p] = 5'($urandom_range(0, 31));

        for (p = 0; p < 10; p++)
        begin
            settle();
            write_bases(bases_plan[p]);
            no_idle = (p % 4 == 2);
            j = 0;
            // reload the whole table before evaluating on odd phases
            if (p % 2 == 1)
            begin
                for (j = 0; j < NUM_WEIGHTS; j++)
                    push_write(4'(j), rand_weight());
            end
            for (; j < 55; j++)
            begin
                if ($urandom_range(0, 99) < 35)
                    push_write(4'($urandom_range(0, 15)), rand_weight());
                else
                    push_eval(rand_point());
            end
        end

        settle();
        no_idle = 1'b0;
        repeat (30) @(posedge clk);
        if (expected_sums.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_sums.size());
            n_errors++;
        end
        $display("Ran %0d weight writes and %0d evaluations (%0d clipped, %0d checked)",
                 n_writes, n_evals, n_sat, n_checked);
        $display("across %0d base-count settings, with and without handshake gaps",
                 n_settings + 1);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/csev_pkg.sv
hw/rtl/csev_ram.sv
hw/rtl/csev_cos_rom.sv
hw/rtl/csev_mac.sv
hw/rtl/cosine_series_evaluator.sv
sim/tb_top.sv
